// File: hw/rtl/c2p_pkg.sv
// ----------------------------------------------------------------------------
// c2p_pkg
// Types shared by the chunky-to-planar span packer and its word interfaces.
// ----------------------------------------------------------------------------
package c2p_pkg;

	localparam int unsigned PLANES = 4;

	typedef struct packed {
		logic [7:0] pixel;
		logic       first;
		logic       last;
		logic [9:0] start_x;
		logic [8:0] row_y;
	} pix_word_t;

	typedef struct packed {
		logic [15:0] byte_offset;
		logic [7:0]  plane0_byte;
		logic [7:0]  plane1_byte;
		logic [7:0]  plane2_byte;
		logic [7:0]  plane3_byte;
		logic [7:0]  write_mask;
		logic        end_of_row;
	} plane_word_t;

endpackage

// File: hw/rtl/c2p_pix_if.sv
// ----------------------------------------------------------------------------
// c2p_pix_if
// Valid/ready channel carrying one colour-index pixel word per transfer.
// ----------------------------------------------------------------------------
interface c2p_pix_if;
	import c2p_pkg::*;

	logic      valid;
	logic      ready;
	pix_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/c2p_plane_if.sv
// ----------------------------------------------------------------------------
// c2p_plane_if
// Valid/ready channel carrying one masked four-plane byte word per transfer.
// ----------------------------------------------------------------------------
interface c2p_plane_if;
	import c2p_pkg::*;

	logic        valid;
	logic        ready;
	plane_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/chunky_to_planar_span_packer.sv
// ----------------------------------------------------------------------------
// chunky_to_planar_span_packer
// Spreads colour bits 0 to 3 of a pixel span into four bit planes and emits
// one masked plane word per completed or partial destination byte.
// ----------------------------------------------------------------------------
// Output: a registered plane word appears in the cycle after its completing pixel.
// Throughput: one pixel word per cycle; a single output register holds the result,
// and the input stalls only while that register is full and not being taken.
// Reset: arst_n clears the column, row base, accumulated planes and the output
// valid flag, so pixels before any first word land from column 0 of row 0.
module chunky_to_planar_span_packer #(
	parameter int unsigned FRAME_WIDTH  = 640,
	parameter int unsigned FRAME_HEIGHT = 480
) (
	input logic        clk,
	input logic        arst_n,
	c2p_pix_if.sink    pix,
	c2p_plane_if.source wr
);
	import c2p_pkg::*;

	localparam int unsigned PITCH = (FRAME_WIDTH + 7) / 8;
	localparam int unsigned CW    = $clog2(FRAME_WIDTH + 1);
	localparam logic [CW-1:0] COL_END = CW'(FRAME_WIDTH);

	logic [CW-1:0]          col_q;
	logic [15:0]            base_q;
	logic [PLANES*8-1:0]    acc_q;
	logic [7:0]             cov_q;
	logic                   res_valid_q;
	plane_word_t            res_q;

	logic                   accept;
	logic                   drop_span;
	logic [CW-1:0]          col_eff;
	logic [CW-1:0]          col_inc;
	logic [15:0]            base_eff;
	logic [PLANES*8-1:0]    acc_eff;
	logic [7:0]             cov_eff;
	logic [7:0]             bit_sel;
	logic [PLANES*8-1:0]    acc_new;
	logic [7:0]             cov_new;
	logic                   in_frame;
	logic                   done;
	logic                   emit;
	logic [CW-1:0]          col_next;

	assign accept   = pix.valid && pix.ready;
	assign pix.ready = !res_valid_q || wr.ready;

	always_comb begin
		drop_span = (32'(pix.data.row_y) >= 32'(FRAME_HEIGHT)) ||
			(32'(pix.data.start_x) >= 32'(FRAME_WIDTH));
		if (pix.data.first) begin
			col_eff  = drop_span ? COL_END : CW'(pix.data.start_x);
			base_eff = {7'b0, pix.data.row_y} * 16'(PITCH);
			acc_eff  = '0;
			cov_eff  = '0;
		end else begin
			col_eff  = col_q;
			base_eff = base_q;
			acc_eff  = acc_q;
			cov_eff  = cov_q;
		end

		in_frame = col_eff < COL_END;
		col_inc  = col_eff + CW'(1);
		bit_sel  = 8'h80 >> col_eff[2:0];
		acc_new  = acc_eff;
		for (int i = 0; i < PLANES; i++) begin
			if (pix.data.pixel[i]) begin
				acc_new[i*8 +: 8] = acc_eff[i*8 +: 8] | bit_sel;
			end
		end
		cov_new = cov_eff | bit_sel;

		done = pix.data.last || (col_eff[2:0] == 3'd7) || (col_inc == COL_END);
		emit = in_frame && done;
		if (!in_frame) begin
			col_next = col_eff;
		end else if (pix.data.last) begin
			col_next = COL_END;
		end else begin
			col_next = col_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			base_q      <= '0;
			acc_q       <= '0;
			cov_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				col_q  <= col_next;
				base_q <= base_eff;
				if (!in_frame) begin
					acc_q <= acc_eff;
					cov_q <= cov_eff;
				end else if (done) begin
					acc_q <= '0;
					cov_q <= '0;
				end else begin
					acc_q <= acc_new;
					cov_q <= cov_new;
				end
			end
			if (accept && emit) begin
				res_valid_q <= 1'b1;
			end else if (wr.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			res_q.byte_offset <= base_eff + 16'(col_eff >> 3);
			res_q.plane0_byte <= acc_new[7:0];
			res_q.plane1_byte <= acc_new[15:8];
			res_q.plane2_byte <= acc_new[23:16];
			res_q.plane3_byte <= acc_new[31:24];
			res_q.write_mask  <= cov_new;
			res_q.end_of_row  <= pix.data.last;
		end
	end

	assign wr.valid = res_valid_q;
	assign wr.data  = res_q;

endmodule

// File: hw/rtl/c2p_checker.sv
// ----------------------------------------------------------------------------
// c2p_checker
// Port-level checks on the span packer, bound to its top level.
// ----------------------------------------------------------------------------
module c2p_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       pix_valid,
	input logic       pix_ready,
	input logic       wr_valid,
	input logic       wr_ready,
	input logic [7:0] plane0,
	input logic [7:0] plane1,
	input logic [7:0] plane2,
	input logic [7:0] plane3,
	input logic [7:0] mask
);

	// A pending output word is never withdrawn before it is taken.
	a_wr_hold: assert property (@(posedge clk) disable iff (!arst_n)
		wr_valid && !wr_ready |=> wr_valid)
		else $error("output word withdrawn while stalled");

	// A new output word only follows an accepted pixel word.
	a_wr_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(wr_valid) |-> $past(pix_valid && pix_ready))
		else $error("output word without an accepted pixel word");

	// Every emitted byte covers at least one pixel.
	a_mask_set: assert property (@(posedge clk) disable iff (!arst_n)
		wr_valid |-> mask != 8'h00)
		else $error("empty write mask");

	// Plane bits outside the covered pixels are zero.
	a_plane_in_mask: assert property (@(posedge clk) disable iff (!arst_n)
		wr_valid |-> ((plane0 | plane1 | plane2 | plane3) & ~mask) == 8'h00)
		else $error("plane bit set outside the write mask");

endmodule

bind chunky_to_planar_span_packer c2p_checker u_c2p_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.pix_valid (pix.valid),
	.pix_ready (pix.ready),
	.wr_valid  (wr.valid),
	.wr_ready  (wr.ready),
	.plane0    (wr.data.plane0_byte),
	.plane1    (wr.data.plane1_byte),
	.plane2    (wr.data.plane2_byte),
	.plane3    (wr.data.plane3_byte),
	.mask      (wr.data.write_mask)
);
